// ===== src/rtbs_pkg.sv =====
// rtbs_pkg: shared types and constants of the range toggle bit store.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package rtbs_pkg;

	// Field widths of the transactions and the length register
	localparam int IDX_W = 12;
	localparam int LEN_W = 13;

	// One block of flip marks covers one stored word
	localparam int BLOCK_BITS  = 64;
	localparam int BLOCK_SHIFT = 6;

	// Number of blocks the index field can reach
	localparam int IDX_BLOCKS = (1 << IDX_W) / BLOCK_BITS;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_FLIP  = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	// How the datapath builds the word it writes back
	typedef enum logic [1:0] {
		WK_LOAD       = 2'd0,
		WK_FLIP_FIRST = 2'd1,
		WK_FLIP_LAST  = 2'd2
	} wr_kind_t;

	// Controller to datapath
	typedef struct packed {
		logic     capture;
		logic     mark_clear;
		logic     mark_flip;
		logic     rd_en;
		logic     rd_last;
		logic     wr_en;
		wr_kind_t wr_kind;
		logic     out_load;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		action_t action;
		logic    range_empty;
		logic    first_partial;
		logic    last_partial;
		logic    pos_valid;
		logic    out_busy;
	} ctl_sts_t;

endpackage

// ===== src/rtbs_if.sv =====
// rtbs_if: valid/ready channel interfaces for the item and result transactions.
// Depends on rtbs_pkg for the action type and field widths.
interface rtbs_item_if
	import rtbs_pkg::*;
;
	logic             valid;
	logic             ready;
	action_t          action;
	logic [IDX_W-1:0] first_index;
	logic [IDX_W-1:0] last_index;
	logic             bit_in;

	modport source (output valid, action, first_index, last_index, bit_in, input ready);
	modport sink   (input valid, action, first_index, last_index, bit_in, output ready);
endinterface

interface rtbs_result_if;
	logic valid;
	logic ready;
	logic bit_value;
	logic index_error;

	modport source (output valid, bit_value, index_error, input ready);
	modport sink   (input valid, bit_value, index_error, output ready);
endinterface

// ===== src/rtbs_ram.sv =====
// rtbs_ram: generic single write port, single read port RAM with registered read.
// Depends on nothing.
module rtbs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/rtbs_ctrl.sv =====
// rtbs_ctrl: sequencing state machine of the range toggle bit store.
// Depends on rtbs_pkg for the command and status structs.
module rtbs_ctrl
	import rtbs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MOD_FIRST,
		ST_MOD_LAST,
		ST_QUERY
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd        = '0;
		cmd.wr_kind = WK_LOAD;
		state_nxt  = state_q;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_nxt = ST_IDLE;
				case (sts.action)
					ACT_CLEAR: begin
						cmd.mark_clear = 1'b1;
					end
					ACT_LOAD: begin
						if (sts.pos_valid) begin
							cmd.rd_en = 1'b1;
							state_nxt = ST_MOD_FIRST;
						end
					end
					ACT_FLIP: begin
						if (!sts.range_empty) begin
							cmd.mark_flip = 1'b1;
							if (sts.first_partial) begin
								cmd.rd_en = 1'b1;
								state_nxt = ST_MOD_FIRST;
							end else if (sts.last_partial) begin
								cmd.rd_en   = 1'b1;
								cmd.rd_last = 1'b1;
								state_nxt   = ST_MOD_LAST;
							end
						end
					end
					ACT_QUERY: begin
						cmd.rd_en = 1'b1;
						state_nxt = ST_QUERY;
					end
					default: begin
						state_nxt = ST_IDLE;
					end
				endcase
			end
			ST_MOD_FIRST: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_kind = (sts.action == ACT_LOAD) ? WK_LOAD : WK_FLIP_FIRST;
				state_nxt   = ST_IDLE;
				if (sts.action == ACT_FLIP && sts.last_partial) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_last = 1'b1;
					state_nxt   = ST_MOD_LAST;
				end
			end
			ST_MOD_LAST: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_kind = WK_FLIP_LAST;
				state_nxt   = ST_IDLE;
			end
			ST_QUERY: begin
				// hold the read word until the result slot frees up
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== src/rtbs_dp.sv =====
// rtbs_dp: datapath of the range toggle bit store: item and length registers,
// range decode, flip marks, word memory and result register.
// Depends on rtbs_pkg and rtbs_ram.
module rtbs_dp
	import rtbs_pkg::*;
#(
	parameter int MAX_BITS = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  action_t          action,
	input  logic [IDX_W-1:0] first_index,
	input  logic [IDX_W-1:0] last_index,
	input  logic             bit_in,
	input  ctl_cmd_t         cmd,
	output ctl_sts_t         sts,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             bit_value,
	output logic             index_error
);

	localparam int RAW_WORDS = (MAX_BITS + BLOCK_BITS - 1) / BLOCK_BITS;
	localparam int WORDS     = (RAW_WORDS < IDX_BLOCKS) ? RAW_WORDS : IDX_BLOCKS;
	localparam int AW        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LEN_MAX   = (1 << LEN_W) - 1;
	localparam int CAP_INT   = (MAX_BITS < LEN_MAX) ? MAX_BITS : LEN_MAX;
	localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP_INT);
	localparam int BW        = IDX_W - BLOCK_SHIFT;

	// Item and length registers
	action_t          act_q;
	logic [IDX_W-1:0] first_q;
	logic [IDX_W-1:0] last_q;
	logic             bin_q;
	logic [LEN_W-1:0] bit_count_q;

	// Result register state
	logic out_valid_q;
	logic bit_value_q;
	logic index_error_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q   <= action;
			first_q <= first_index;
			last_q  <= last_index;
			bin_q   <= bit_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= '0;
		end else if (cfg_we) begin
			bit_count_q <= cfg_wdata;
		end
	end

	// Range decode
	logic [LEN_W-1:0]       eff_len;
	logic [LEN_W-1:0]       len_m1;
	logic [IDX_W-1:0]       hi_clip;
	logic [BW-1:0]          bfirst;
	logic [BW-1:0]          blast;
	logic [BLOCK_SHIFT-1:0] lo_off;
	logic [BLOCK_SHIFT-1:0] hi_off;
	logic                   full_lo;
	logic                   full_hi;
	logic                   single;
	logic                   pos_valid;

	assign eff_len   = (bit_count_q > CAP_LEN) ? CAP_LEN : bit_count_q;
	assign len_m1    = eff_len - LEN_W'(1);
	assign hi_clip   = ({1'b0, last_q} >= eff_len) ? len_m1[IDX_W-1:0] : last_q;
	assign bfirst    = first_q[IDX_W-1:BLOCK_SHIFT];
	assign blast     = hi_clip[IDX_W-1:BLOCK_SHIFT];
	assign lo_off    = first_q[BLOCK_SHIFT-1:0];
	assign hi_off    = hi_clip[BLOCK_SHIFT-1:0];
	assign full_lo   = (lo_off == '0);
	assign full_hi   = (&hi_off);
	assign single    = (bfirst == blast);
	assign pos_valid = ({1'b0, first_q} < eff_len);

	always_comb begin
		sts.action        = act_q;
		sts.range_empty   = (eff_len == '0) || (first_q > hi_clip);
		sts.first_partial = !(full_lo && (!single || full_hi));
		sts.last_partial  = !single && !full_hi;
		sts.pos_valid     = pos_valid;
		sts.out_busy      = out_valid_q && !out_ready;
	end

	// Edge word masks and the set of whole blocks to toggle
	logic [BLOCK_BITS-1:0]  mask_first;
	logic [BLOCK_BITS-1:0]  mask_last;
	logic [BLOCK_SHIFT-1:0] top_first;
	logic [WORDS-1:0]       flip_sel;

	assign top_first = single ? hi_off : '1;

	always_comb begin
		for (int k = 0; k < BLOCK_BITS; k++) begin
			mask_first[k] = (BLOCK_SHIFT'(k) >= lo_off) && (BLOCK_SHIFT'(k) <= top_first);
			mask_last[k]  = (BLOCK_SHIFT'(k) <= hi_off);
		end
		for (int b = 0; b < WORDS; b++) begin
			flip_sel[b] = (BW'(b) >= bfirst) && (BW'(b) <= blast)
				&& ((BW'(b) != bfirst) || full_lo)
				&& ((BW'(b) != blast) || full_hi);
		end
	end

	// Flip marks
	logic [WORDS-1:0] marks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q <= '0;
		end else if (cmd.mark_clear) begin
			marks_q <= '0;
		end else if (cmd.mark_flip) begin
			marks_q <= marks_q ^ flip_sel;
		end
	end

	// Word memory
	logic [AW-1:0]         first_addr;
	logic [AW-1:0]         last_addr;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [BLOCK_BITS-1:0] rd_data;
	logic [BLOCK_BITS-1:0] wr_data;
	logic [BLOCK_BITS-1:0] bit_sel;

	assign first_addr = AW'(bfirst);
	assign last_addr  = AW'(blast);
	assign rd_addr    = cmd.rd_last ? last_addr : first_addr;
	assign wr_addr    = (cmd.wr_kind == WK_FLIP_LAST) ? last_addr : first_addr;
	assign bit_sel    = BLOCK_BITS'(1) << lo_off;

	always_comb begin
		case (cmd.wr_kind)
			WK_LOAD:       wr_data = (rd_data & ~bit_sel) | (bin_q ? bit_sel : '0);
			WK_FLIP_FIRST: wr_data = rd_data ^ mask_first;
			WK_FLIP_LAST:  wr_data = rd_data ^ mask_last;
			default:       wr_data = rd_data;
		endcase
	end

	rtbs_ram #(
		.WIDTH (BLOCK_BITS),
		.DEPTH (WORDS)
	) u_words (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			index_error_q <= !pos_valid;
			bit_value_q   <= pos_valid ? (rd_data[lo_off] ^ marks_q[first_addr]) : 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign bit_value   = bit_value_q;
	assign index_error = index_error_q;

endmodule

// ===== src/range_toggle_bit_store.sv =====
// range_toggle_bit_store: top level of the range toggle bit store.
// Depends on rtbs_pkg, rtbs_if, rtbs_ctrl and rtbs_dp (which holds rtbs_ram).
//
// Stores a string of bit_count bits (capped at MAX_BITS) in 64-bit words, with
// one flip mark per 64-bit block. Each item transaction on cmd is one action:
// clear resets all flip marks (stored bits stay), load writes one raw bit (a
// position at or past the length is dropped), flip inverts the range from
// first_index to last_index (last_index is clipped to the length, an empty
// range does nothing; whole blocks only toggle their mark, the one or two
// partly covered edge blocks get a read-modify-write of their word), and query
// returns the stored bit XOR its block mark on result, or index_error with
// bit_value 0 for a position at or past the length. Only a query produces a
// result transaction. Items run one at a time: each accepted item passes a
// decode state; a load within the length, a query and each partly covered
// edge word of a flip then take a further state for the word access, as the
// word memory has one read and one write port; a query waits further while
// an earlier result still sits untaken in the result register. The user must
// write the length register through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce it. Stored words have no reset; a
// query of a position that no load ever wrote returns an undefined value.
module range_toggle_bit_store
	import rtbs_pkg::*;
#(
	parameter int MAX_BITS = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	rtbs_item_if.sink        cmd,
	rtbs_result_if.source    result
);

	ctl_cmd_t ctl_cmd;
	ctl_sts_t ctl_sts;
	logic     in_ready;

	// Sequence each item through decode, memory access and result load
	rtbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	assign cmd.ready = in_ready;

	// Hold the item, length, marks and words; drive the result register
	rtbs_dp #(
		.MAX_BITS (MAX_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.action      (cmd.action),
		.first_index (cmd.first_index),
		.last_index  (cmd.last_index),
		.bit_in      (cmd.bit_in),
		.cmd         (ctl_cmd),
		.sts         (ctl_sts),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.bit_value   (result.bit_value),
		.index_error (result.index_error)
	);

	// An accepted item keeps the input closed at least through its decode state
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("item accepted while previous item still in decode");

	// Never overwrite a result that the sink has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.out_load |-> !(result.valid && !result.ready))
		else $error("result register loaded while still occupied");

	// A result appears only from a query load
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(ctl_cmd.out_load))
		else $error("result valid rose without a load");

	// A cycle that both writes and reads the words reads the other edge word
	a_rw_split: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_cmd.wr_en && ctl_cmd.rd_en) |-> (ctl_cmd.rd_last && ctl_cmd.wr_kind == WK_FLIP_FIRST))
		else $error("word read and write collide");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench of range_toggle_bit_store.
// Depends on rtbs_pkg, the rtbs_if channel interfaces and the block's RTL.
module tb_top
	import rtbs_pkg::*;
;

	localparam int STORE_BITS    = 4096;
	localparam int WORDS         = STORE_BITS / BLOCK_BITS;
	// Leave margin for the longest item to finish before a register write
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int MAX_PRINTED   = 40;
	localparam int PHASE_ITEMS   = 48;
	localparam int FILL_ITEMS    = 80;

	// One answer the store owes for a query
	typedef struct packed {
		logic bit_value;
		logic index_error;
	} read_answer_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	rtbs_item_if   cmd_if ();
	rtbs_result_if res_if ();

	range_toggle_bit_store #(
		.MAX_BITS (STORE_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_if),
		.result    (res_if)
	);

	always #4 clk = ~clk;

	// Shadow copy of the store: raw words, block marks and the length register.
	// pos_written tracks which positions hold a defined bit, so that no query
	// ever lands on a position the store never had written; written_pos lists
	// them for picking query targets.
	logic [63:0]  shadow_words [WORDS];
	logic         shadow_marks [WORDS];
	logic         pos_written  [STORE_BITS];
	int           written_pos  [$];
	int           shadow_len;
	read_answer_t pending_reads [$];

	int fail_count  = 0;
	int cycle_count = 0;
	int ready_hold  = 0;
	bit tx_idle_en  = 1'b1;
	bit rx_stall_en = 1'b1;

	// Length as the store sees it: anything above the capacity acts as full
	function automatic int live_len();
		return (shadow_len > STORE_BITS) ? STORE_BITS : shadow_len;
	endfunction

	// Mostly no gap or a short one, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the shadow store by one accepted transaction; a query queues
	// the answer it owes.
	function automatic void apply_action(action_t act, logic [IDX_W-1:0] first,
			logic [IDX_W-1:0] last, logic bin);
		int           n;
		int           lo;
		int           hi;
		int           b;
		int           p;
		int           s;
		int           e;
		read_answer_t ans;
		n  = live_len();
		lo = first;
		hi = last;
		case (act)
			ACT_CLEAR: begin
				// Marks only; the raw words keep their bits
				foreach (shadow_marks[i])
					shadow_marks[i] = 1'b0;
			end
			ACT_LOAD: begin
				// Raw bit is stored as given, the mark is not folded in
				if (lo < n) begin
					shadow_words[lo / BLOCK_BITS][lo % BLOCK_BITS] = bin;
					if (!pos_written[lo])
						written_pos = {written_pos, lo};
					pos_written[lo] = 1'b1;
				end
			end
			ACT_FLIP: begin
				if (n != 0) begin
					if (hi >= n)
						hi = n - 1;
					if (lo <= hi) begin
						for (b = lo / BLOCK_BITS; b <= hi / BLOCK_BITS; b++) begin
							s = b * BLOCK_BITS;
							e = s + BLOCK_BITS - 1;
							if (lo <= s && e <= hi) begin
								// Whole block: toggle its mark only
								shadow_marks[b] = ~shadow_marks[b];
							end else begin
								// Edge block: invert the covered positions one by one
								if (lo > s)
									s = lo;
								if (hi < e)
									e = hi;
								for (p = s; p <= e; p++)
									shadow_words[p / BLOCK_BITS][p % BLOCK_BITS] ^= 1'b1;
							end
						end
					end
				end
			end
			ACT_QUERY: begin
				if (lo >= n) begin
					ans = '{1'b0, 1'b1};
				end else begin
					ans = '{shadow_words[lo / BLOCK_BITS][lo % BLOCK_BITS]
						^ shadow_marks[lo / BLOCK_BITS], 1'b0};
				end
				pending_reads = {pending_reads, ans};
			end
			default: begin
			end
		endcase
	endfunction

	task automatic report_mismatch(string what);
		fail_count++;
		if (fail_count <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Drive one item transaction, hold it until accepted, then predict.
	// Returns at the accepting edge with valid still high.
	task automatic send_item(action_t act, logic [IDX_W-1:0] first,
			logic [IDX_W-1:0] last, logic bin);
		int gap;
		gap = tx_idle_en ? idle_length() : 0;
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid       <= 1'b1;
		cmd_if.action      <= act;
		cmd_if.first_index <= first;
		cmd_if.last_index  <= last;
		cmd_if.bit_in      <= bin;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		apply_action(act, first, last, bin);
	endtask

	// Drop valid, wait for every owed answer, then let any item that owes no
	// answer finish inside the block.
	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(int value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= LEN_W'(value);
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_len = value % (1 << LEN_W);
	endtask

	// Query a position; an in-range position with no defined bit gets a load
	// instead so the store is never asked for an undefined bit.
	task automatic query_or_load(logic [IDX_W-1:0] idx);
		if (idx < live_len() && !pos_written[idx])
			send_item(ACT_LOAD, idx, IDX_W'($urandom), 1'($urandom));
		else
			send_item(ACT_QUERY, idx, IDX_W'($urandom), 1'($urandom));
	endtask

	// Favor positions that already hold a defined bit
	function automatic logic [IDX_W-1:0] pick_query_index();
		int n;
		int r;
		int pick;
		n = live_len();
		r = $urandom_range(0, 19);
		if (n > 0 && r < 8 && written_pos.size() != 0) begin
			pick = written_pos[$urandom_range(0, written_pos.size() - 1)];
			if (pick < n)
				return IDX_W'(pick);
		end
		if (n > 0 && r < 12)
			return IDX_W'($urandom_range(0, n - 1));
		if (r < 15 && n < STORE_BITS)
			return IDX_W'(n);
		if (r < 17 && n > 0)
			return IDX_W'(n - 1);
		return IDX_W'($urandom);
	endfunction

	// Ranges: anything at all, short ones across block borders, runs of whole
	// blocks, and ones that run past the length.
	function automatic void pick_flip_range(output logic [IDX_W-1:0] lo,
			output logic [IDX_W-1:0] hi);
		int n;
		int k;
		int top;
		n = live_len();
		case ($urandom_range(0, 3))
			0: begin
				lo = IDX_W'($urandom);
				hi = IDX_W'($urandom);
			end
			1: begin
				lo = IDX_W'($urandom);
				hi = lo + IDX_W'($urandom_range(0, 130));
			end
			2: begin
				k   = $urandom_range(0, WORDS - 1);
				top = (k + $urandom_range(0, 8)) * BLOCK_BITS + BLOCK_BITS - 1;
				if (top > STORE_BITS - 1)
					top = STORE_BITS - 1;
				lo = IDX_W'(k * BLOCK_BITS + (($urandom_range(0, 3) == 0) ? 1 : 0));
				hi = IDX_W'(top - (($urandom_range(0, 3) == 0) ? 1 : 0));
			end
			default: begin
				lo = (n > 0) ? IDX_W'($urandom_range(0, n - 1)) : IDX_W'($urandom);
				hi = '1;
			end
		endcase
	endfunction

	// Length register at reset is zero: every load and flip is dropped and
	// every query flags an index error.
	task automatic test_length_zero();
		send_item(ACT_LOAD, '0, '0, 1'b1);
		send_item(ACT_FLIP, '0, '1, 1'b0);
		send_item(ACT_QUERY, '0, '0, 1'b0);
		send_item(ACT_QUERY, '1, '1, 1'b1);
		send_item(ACT_CLEAR, '1, '0, 1'b1);
	endtask

	// Give the positions the directed tests query, and a spread of random
	// ones, a defined bit at full length, back to back
	task automatic test_fill_store();
		int spots [9];
		bit saved_tx;
		bit saved_rx;
		spots    = '{0, 5, 63, 64, 99, 100, 127, 128, STORE_BITS - 1};
		saved_tx = tx_idle_en;
		saved_rx = rx_stall_en;
		set_length(STORE_BITS);
		tx_idle_en  = 1'b0;
		rx_stall_en = 1'b0;
		foreach (spots[i])
			send_item(ACT_LOAD, IDX_W'(spots[i]), IDX_W'($urandom), 1'($urandom));
		for (int k = 0; k < FILL_ITEMS; k++)
			send_item(ACT_LOAD, IDX_W'($urandom_range(0, STORE_BITS - 1)),
				IDX_W'($urandom), 1'($urandom));
		tx_idle_en  = saved_tx;
		rx_stall_en = saved_rx;
	endtask

	// Full range, a lone bit, a pair of edge blocks, a whole block, an empty range,
	// clear, and a load under a set mark.
	task automatic test_flip_shapes();
		send_item(ACT_FLIP, '0, '1, 1'b0);
		send_item(ACT_QUERY, '0, '0, 1'b0);
		send_item(ACT_QUERY, '1, '0, 1'b0);
		send_item(ACT_FLIP, 12'd5, 12'd5, 1'b0);
		send_item(ACT_QUERY, 12'd5, '0, 1'b0);
		send_item(ACT_FLIP, 12'd60, 12'd70, 1'b1);
		send_item(ACT_QUERY, 12'd64, '0, 1'b0);
		send_item(ACT_FLIP, 12'd64, 12'd127, 1'b0);
		send_item(ACT_FLIP, 12'd100, 12'd50, 1'b0);
		send_item(ACT_QUERY, 12'd100, '0, 1'b0);
		send_item(ACT_CLEAR, '0, '0, 1'b0);
		send_item(ACT_QUERY, 12'd100, '0, 1'b0);
		send_item(ACT_FLIP, 12'd128, 12'd191, 1'b0);
		send_item(ACT_LOAD, 12'd130, '0, 1'b1);
		send_item(ACT_QUERY, 12'd130, '0, 1'b0);
	endtask

	// Clipping of the range end to the length, loads past the length, and a
	// register value above the capacity.
	task automatic test_length_clipping();
		set_length(100);
		send_item(ACT_FLIP, 12'd50, 12'd4000, 1'b0);
		send_item(ACT_QUERY, 12'd99, '0, 1'b0);
		send_item(ACT_LOAD, 12'd100, '0, 1'b1);
		send_item(ACT_QUERY, 12'd100, '0, 1'b0);
		set_length(1);
		send_item(ACT_FLIP, '0, '0, 1'b0);
		send_item(ACT_QUERY, '0, '0, 1'b0);
		set_length(65);
		send_item(ACT_FLIP, '0, '1, 1'b0);
		send_item(ACT_QUERY, 12'd64, '0, 1'b0);
		set_length((1 << LEN_W) - 1);
		send_item(ACT_FLIP, 12'd4000, '1, 1'b0);
		send_item(ACT_QUERY, '1, '0, 1'b0);
	endtask

	// Phases of random traffic, each at its own length and idling mode
	task automatic test_random_phases();
		int               lengths [8];
		int               r;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		lengths = '{STORE_BITS, 1, (1 << LEN_W) - 1, BLOCK_BITS, 0,
			STORE_BITS - 1, $urandom_range(0, (1 << LEN_W) - 1), BLOCK_BITS + 1};
		for (int ph = 0; ph < 8; ph++) begin
			set_length(lengths[ph]);
			// Two phases run with no idling on either side
			tx_idle_en  = !(ph == 2 || ph == 5);
			rx_stall_en = !(ph == 2 || ph == 5);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 19);
				if (r < 2) begin
					send_item(ACT_CLEAR, IDX_W'($urandom), IDX_W'($urandom), 1'($urandom));
				end else if (r < 6) begin
					send_item(ACT_LOAD, pick_query_index(), IDX_W'($urandom),
						1'($urandom));
				end else if (r < 12) begin
					pick_flip_range(lo, hi);
					send_item(ACT_FLIP, lo, hi, 1'($urandom));
				end else begin
					query_or_load(pick_query_index());
				end
			end
		end
		tx_idle_en  = 1'b1;
		rx_stall_en = 1'b1;
	endtask

	// Result ready: random stalls of varied length, or held high when the
	// phase asks for no idling.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
		end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
			res_if.ready <= 1'b0;
			ready_hold = idle_length();
		end else begin
			res_if.ready <= 1'b1;
			ready_hold = $urandom_range(0, 5);
		end
	end

	// Check each result transaction against the oldest owed answer
	always @(posedge clk) begin : check_reads
		read_answer_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_reads.size() == 0) begin
				report_mismatch("result with no query waiting");
			end else begin
				want = pending_reads.pop_front();
				if (res_if.bit_value !== want.bit_value)
					report_mismatch($sformatf("bit_value %b, want %b",
						res_if.bit_value, want.bit_value));
				if (res_if.index_error !== want.index_error)
					report_mismatch($sformatf("index_error %b, want %b",
						res_if.index_error, want.index_error));
			end
		end
	end

	// Hard stop for a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		// Hold every input at a known value through reset
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		cmd_if.valid       = 1'b0;
		cmd_if.action      = ACT_CLEAR;
		cmd_if.first_index = '0;
		cmd_if.last_index  = '0;
		cmd_if.bit_in      = 1'b0;
		res_if.ready       = 1'b0;
		shadow_len         = 0;
		foreach (shadow_marks[i]) begin
			shadow_marks[i] = 1'b0;
			shadow_words[i] = '0;
		end
		foreach (pos_written[i])
			pos_written[i] = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_length_zero();
		test_fill_store();
		test_flip_shapes();
		test_length_clipping();
		test_random_phases();

		// Drain owed answers and let the last item settle
		wait_idle();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/rtbs_pkg.sv
src/rtbs_if.sv
src/rtbs_ram.sv
src/rtbs_ctrl.sv
src/rtbs_dp.sv
src/range_toggle_bit_store.sv
tb/tb_top.sv
